[rtl/core/eia_pkg.sv]
// shared constants, codes and types of the entity id allocator
package eia_pkg;

  localparam int ENTITIES   = 1024;
  localparam int ID_W       = $clog2(ENTITIES);
  localparam int CNT_W      = $clog2(ENTITIES + 1);
  localparam int COMPONENTS = 32;
  localparam int SIG_W      = COMPONENTS;
  localparam int SYSTEMS    = 4;
  localparam int SYS_IDX_W  = $clog2(SYSTEMS);
  localparam int USE_W      = 3;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SYS_SIG_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IN_USE    = CFG_IDX_W'(4);

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_SET     = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_FULL       = 2'd1,
    STS_NOT_LIVING = 2'd2
  } status_e;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

[rtl/core/eia_ram.sv]
// generic single write port, single read port synchronous ram
module eia_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/eia_member.sv]
// system signature registers and membership mask
module eia_member (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eia_pkg::cfg_wr_t              cfg_i,
  input  logic [eia_pkg::SIG_W-1:0]     sig_i,
  output logic [eia_pkg::SYSTEMS-1:0]   mask_o
);
  import eia_pkg::*;

  logic [SIG_W-1:0] sys_sig_q [SYSTEMS];
  logic [USE_W-1:0] in_use_q;
  logic [USE_W-1:0] n_sys;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SYSTEMS; i++) begin
        sys_sig_q[i] <= '0;
      end
      in_use_q <= '0;
    end else if (cfg_i.we) begin
      if (cfg_i.idx < CFG_IDX_W'(SYSTEMS)) begin
        sys_sig_q[cfg_i.idx[SYS_IDX_W-1:0] - SYS_IDX_W'(CFG_SYS_SIG_0)] <=
          cfg_i.data[SIG_W-1:0];
      end else if (cfg_i.idx == CFG_IN_USE) begin
        in_use_q <= cfg_i.data[USE_W-1:0];
      end
    end
  end

  assign n_sys = (in_use_q > USE_W'(SYSTEMS)) ? USE_W'(SYSTEMS) : in_use_q;

  always_comb begin
    for (int i = 0; i < SYSTEMS; i++) begin
      mask_o[i] = (USE_W'(i) < n_sys) && ((sig_i & sys_sig_q[i]) == sys_sig_q[i]);
    end
  end

endmodule

[rtl/core/entity_id_allocator_with_signatures.sv]
// entity id allocator: fifo free list, living bits and per-entity signatures
// results are registered in the execute state, which holds while the output is stalled;
// create first passes a fetch state (free list read, then entity memory read, and write
// back). A new transaction is taken only when idle, so each finishes before the next
// reset: a clearing pass writes each entity entry, leaving only entity 0 living; no
// transaction is accepted meanwhile; configuration registers reset to zero
module entity_id_allocator_with_signatures (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        op_i,
  input  logic [eia_pkg::ID_W-1:0]          entity_i,
  input  logic [eia_pkg::SIG_W-1:0]         new_signature_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [eia_pkg::ID_W-1:0]          given_id_o,
  output logic [eia_pkg::SIG_W-1:0]         signature_out_o,
  output logic [eia_pkg::SYSTEMS-1:0]       member_mask_o,
  output logic [eia_pkg::CNT_W-1:0]         live_count_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_we_i,
  input  logic [eia_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [eia_pkg::CFG_W-1:0]         cfg_data_i
);
  import eia_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  localparam int EW = SIG_W + 1;

  logic [1:0]       state_q, state_d;
  logic [ID_W-1:0]  clr_q, clr_d;
  logic [ID_W-1:0]  head_q, head_d;
  logic [ID_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0] wr_cnt_q, wr_cnt_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic [ID_W-1:0]  id_q, id_d;

  op_e              op_q;
  logic [ID_W-1:0]  ent_q;
  logic [SIG_W-1:0] nsig_q;

  logic             out_valid_q, out_valid_d;
  logic [ID_W-1:0]  given_q, given_d;
  logic [SIG_W-1:0] sig_q, sig_d;
  logic [SYSTEMS-1:0] mask_q, mask_d;
  logic [CNT_W-1:0] live_out_q;
  status_e          status_q, status_d;

  logic             in_acc;
  logic             out_free;
  logic             in_range;
  logic [ID_W-1:0]  q_id;

  logic             ent_we, ent_re;
  logic [ID_W-1:0]  ent_waddr, ent_raddr;
  logic [EW-1:0]    ent_wdata, ent_rdata;
  logic             q_we, q_re;
  logic [ID_W-1:0]  q_rdata;
  logic             rd_live;
  logic [SIG_W-1:0] rd_sig;
  logic [SYSTEMS-1:0] mask_c;
  cfg_wr_t          cfg;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_range   = ({1'b0, ent_q} < CNT_W'(ENTITIES));
  assign rd_live    = ent_rdata[SIG_W];
  assign rd_sig     = ent_rdata[SIG_W-1:0];
  assign q_id       = ({1'b0, head_q} < wr_cnt_q) ? q_rdata : head_q;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  eia_ram #(.Width(EW), .Depth(ENTITIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  eia_ram #(.Width(ID_W), .Depth(ENTITIES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (ent_q),
    .re_i    (q_re),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  eia_member u_member (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .sig_i  (sig_d),
    .mask_o (mask_c)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    head_d      = head_q;
    tail_d      = tail_q;
    wr_cnt_d    = wr_cnt_q;
    live_d      = live_q;
    id_d        = id_q;
    out_valid_d = out_valid_q && out_stall_i;
    given_d     = '0;
    sig_d       = '0;
    mask_d      = '0;
    status_d    = STS_OK;
    ent_we      = 1'b0;
    ent_waddr   = ent_q;
    ent_wdata   = '0;
    ent_re      = 1'b0;
    ent_raddr   = entity_i;
    q_we        = 1'b0;
    q_re        = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = {(clr_q == '0), {SIG_W{1'b0}}};
        clr_d     = clr_q + 1'b1;
        if (clr_q == ID_W'(ENTITIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ent_re = 1'b1;
          q_re   = (op_e'(op_i) == OP_CREATE);
          state_d = (op_e'(op_i) == OP_CREATE) ? S_FETCH : S_EXEC;
        end
      end
      S_FETCH: begin
        ent_re    = 1'b1;
        ent_raddr = q_id;
        id_d      = q_id;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          case (op_q)
            OP_CREATE: begin
              if (live_q >= CNT_W'(ENTITIES)) begin
                status_d = STS_FULL;
              end else begin
                ent_we    = 1'b1;
                ent_waddr = id_q;
                ent_wdata = {1'b1, rd_sig};
                given_d   = id_q;
                sig_d     = rd_sig;
                head_d    = (head_q == ID_W'(ENTITIES - 1)) ? '0 : head_q + 1'b1;
                live_d    = live_q + 1'b1;
              end
            end
            OP_DESTROY: begin
              if (!in_range || !rd_live) begin
                status_d = STS_NOT_LIVING;
              end else begin
                ent_we = 1'b1;
                q_we   = 1'b1;
                tail_d = (tail_q == ID_W'(ENTITIES - 1)) ? '0 : tail_q + 1'b1;
                live_d = live_q - 1'b1;
                if (wr_cnt_q < CNT_W'(ENTITIES)) begin
                  wr_cnt_d = wr_cnt_q + 1'b1;
                end
              end
            end
            OP_SET: begin
              if (in_range) begin
                ent_we    = 1'b1;
                ent_wdata = {rd_live, nsig_q};
                sig_d     = nsig_q;
              end
              mask_d = mask_c;
            end
            OP_READ: begin
              if (in_range) begin
                sig_d = rd_sig;
              end
              mask_d = mask_c;
            end
            default: begin
              status_d = STS_OK;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= ID_W'(1);
      tail_q      <= '0;
      wr_cnt_q    <= '0;
      live_q      <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      wr_cnt_q    <= wr_cnt_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(op_i);
      ent_q  <= entity_i;
      nsig_q <= new_signature_i;
    end
    id_q <= id_d;
    if (state_q == S_EXEC && out_free) begin
      given_q    <= given_d;
      sig_q      <= sig_d;
      mask_q     <= mask_d;
      live_out_q <= live_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign given_id_o      = given_q;
  assign signature_out_o = sig_q;
  assign member_mask_o   = mask_q;
  assign live_count_o    = live_out_q;
  assign status_o        = status_q;

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(ENTITIES))
    else $error("live count above pool size");

  a_queue_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ID_W'(head_q - tail_q) == live_q[ID_W-1:0])
    else $error("free list span disagrees with live count");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cnt_q <= CNT_W'(ENTITIES))
    else $error("free list fill count overflow");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("result without execute step");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("transaction started during clearing pass");

endmodule
